### src/md5_pkg.sv
// md5 digest package: round constants, helper functions, control and status types
`timescale 1ns / 1ps

package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  typedef struct packed {
    logic accept;      // take input word, write bytes below the block end
    logic tail_write;  // write bytes that spilled past the block end
    logic pad_write;   // 0x80, zeros, and length when it fits
    logic len_write;   // second padding block: zeros and length
    logic comp_start;  // load working registers from chaining values
    logic round;       // one compression round
    logic comp_fin;    // add working registers into chaining values
    logic emit_adv;    // digest word taken
    logic init;        // restart for the next message
  } cmd_t;

  typedef struct packed {
    logic in_wrap;
    logic in_last;
    logic hold_last;
    logic pad_long;
    logic round_last;
    logic emit_last;
  } status_t;

  // message word index used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0: msg_index = lo;
      2'd1: msg_index = lo * 4'd5 + 4'd1;
      2'd2: msg_index = lo * 4'd3 + 4'd5;
      2'd3: msg_index = lo * 4'd7;
      default: msg_index = lo;
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    case ({r[5:4], r[1:0]})
      4'd0: rot_amount = 5'd7;
      4'd1: rot_amount = 5'd12;
      4'd2: rot_amount = 5'd17;
      4'd3: rot_amount = 5'd22;
      4'd4: rot_amount = 5'd5;
      4'd5: rot_amount = 5'd9;
      4'd6: rot_amount = 5'd14;
      4'd7: rot_amount = 5'd20;
      4'd8: rot_amount = 5'd4;
      4'd9: rot_amount = 5'd11;
      4'd10: rot_amount = 5'd16;
      4'd11: rot_amount = 5'd23;
      4'd12: rot_amount = 5'd6;
      4'd13: rot_amount = 5'd10;
      4'd14: rot_amount = 5'd15;
      4'd15: rot_amount = 5'd21;
      default: rot_amount = 5'd7;
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    rotl = t[63:32];
  endfunction

endpackage

### src/md5_in_if.sv
// input channel: message words with byte count and end-of-message flag
`timescale 1ns / 1ps

interface md5_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last,
                output ready);
endinterface

### src/md5_out_if.sv
// output channel: digest words
`timescale 1ns / 1ps

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

### src/md5_ctrl.sv
// md5 controller: sequences absorb, padding, compression and digest output
`timescale 1ns / 1ps

module md5_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  md5_pkg::status_t   st,
  output md5_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAIL  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_PRE   = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [1:0] RET_TAIL = 2'd0;
  localparam logic [1:0] RET_LEN  = 2'd1;
  localparam logic [1:0] RET_EMIT = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_TAIL;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.in_wrap) begin
            ret_next   = RET_TAIL;
            state_next = S_PRE;
          end else if (st.in_last) begin
            state_next = S_PAD;
          end
        end
      end
      S_TAIL: begin
        cmd.tail_write = 1'b1;
        state_next = st.hold_last ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.pad_write = 1'b1;
        // length does not fit: one more block follows
        ret_next   = st.pad_long ? RET_LEN : RET_EMIT;
        state_next = S_PRE;
      end
      S_LEN: begin
        cmd.len_write = 1'b1;
        ret_next   = RET_EMIT;
        state_next = S_PRE;
      end
      S_PRE: begin
        cmd.comp_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (st.round_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.comp_fin = 1'b1;
        case (ret)
          RET_TAIL: state_next = S_TAIL;
          RET_LEN:  state_next = S_LEN;
          RET_EMIT: state_next = S_EMIT;
          default:  state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (st.emit_last) begin
            cmd.init   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while digest is out");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_ready && st.emit_last) |=> state == S_IDLE)
    else $error("no return to idle after final digest word");

  a_pre_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRE) |=> (state == S_ROUND))
    else $error("compression did not start rounds");

endmodule

### src/md5_dp.sv
// md5 datapath: block buffer, bit count, round unit and chaining values
`timescale 1ns / 1ps

module md5_dp (
  input  logic               clk,
  input  logic               rst,
  input  md5_pkg::cmd_t      cmd,
  output md5_pkg::status_t   st,
  input  logic [31:0]        data_word,
  input  logic [2:0]         byte_count,
  input  logic               last,
  output logic [31:0]        digest_word,
  output logic [1:0]         word_index,
  output logic               last_word
);

  logic [31:0] blk [16];
  logic [31:0] chain [4];
  logic [63:0] bit_count;
  logic [5:0]  fill;

  logic [31:0] hold_data;
  logic [2:0]  hold_cnt;
  logic [5:0]  hold_fill;
  logic        hold_last;

  logic [31:0] a, b, c, d, km;
  logic [5:0]  r;
  logic [1:0]  widx;

  logic [2:0]  cnt4;
  logic [6:0]  fill_sum;
  logic [6:0]  acc_pos [4];
  logic [6:0]  tail_pos [4];
  logic        pad_long;

  logic [5:0]  rk;
  logic [31:0] f, sum, m_word;

  assign cnt4     = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign fill_sum = {1'b0, fill} + {4'd0, cnt4};
  assign pad_long = fill >= 6'd56;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_pos[i]  = {1'b0, fill} + 7'(i);
      tail_pos[i] = {1'b0, hold_fill} + 7'(i);
    end
  end

  assign st.in_wrap    = fill_sum[6];
  assign st.in_last    = last;
  assign st.hold_last  = hold_last;
  assign st.pad_long   = pad_long;
  assign st.round_last = (r == 6'd63);
  assign st.emit_last  = (widx == 2'd3);

  // input hold for the spill-over bytes and the pending end of message
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_data <= data_word;
      hold_cnt  <= cnt4;
      hold_fill <= fill;
      hold_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      fill      <= '0;
      bit_count <= '0;
    end else if (cmd.accept) begin
      fill      <= fill_sum[5:0];
      bit_count <= bit_count + {58'd0, cnt4, 3'b000};
    end
  end

  // byte-granular block buffer writes
  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      for (int l = 0; l < 4; l++) begin
        if (cmd.accept) begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < cnt4 && acc_pos[i] == 7'(w * 4 + l))
              blk[w][8 * l +: 8] <= data_word[8 * i +: 8];
          end
        end
        if (cmd.tail_write) begin
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < hold_cnt && tail_pos[i][6] && tail_pos[i][5:0] == 6'(w * 4 + l))
              blk[w][8 * l +: 8] <= hold_data[8 * i +: 8];
          end
        end
        if (cmd.pad_write) begin
          if (!pad_long && w >= 14)
            blk[w][8 * l +: 8] <= (w == 14) ? bit_count[8 * l +: 8] : bit_count[32 + 8 * l +: 8];
          else if (fill == 6'(w * 4 + l))
            blk[w][8 * l +: 8] <= md5_pkg::PAD_BYTE;
          else if (fill < 6'(w * 4 + l))
            blk[w][8 * l +: 8] <= 8'd0;
        end
        if (cmd.len_write) begin
          if (w == 14)
            blk[w][8 * l +: 8] <= bit_count[8 * l +: 8];
          else if (w == 15)
            blk[w][8 * l +: 8] <= bit_count[32 + 8 * l +: 8];
          else
            blk[w][8 * l +: 8] <= 8'd0;
        end
      end
    end
  end

  // constant plus message word is prepared one round ahead
  assign rk     = cmd.comp_start ? 6'd0 : r + 6'd1;
  assign m_word = blk[md5_pkg::msg_index(rk)];

  always_comb begin
    case (r[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign sum = a + f + km;

  always_ff @(posedge clk) begin
    if (cmd.comp_start || cmd.round) km <= md5_pkg::K_TABLE[rk] + m_word;
    if (cmd.comp_start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (cmd.round) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + md5_pkg::rotl(sum, md5_pkg::rot_amount(r));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
    end else if (cmd.comp_start) begin
      r <= '0;
    end else if (cmd.round) begin
      r <= r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      chain[0] <= md5_pkg::INIT_A;
      chain[1] <= md5_pkg::INIT_B;
      chain[2] <= md5_pkg::INIT_C;
      chain[3] <= md5_pkg::INIT_D;
    end else if (cmd.comp_fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
    end else if (cmd.emit_adv) begin
      widx <= widx + 2'd1;
    end
  end

  assign digest_word = chain[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 2'd3);

  a_start_clears_round: assert property (@(posedge clk) disable iff (rst)
    cmd.comp_start |=> (r == 6'd0))
    else $error("round counter not cleared at compression start");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.init |=> (fill == 6'd0 && bit_count == 64'd0 && widx == 2'd0))
    else $error("message state not cleared after digest");

  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> !(cmd.accept || cmd.tail_write || cmd.pad_write || cmd.len_write))
    else $error("block buffer written during compression");

endmodule

### src/md5_message_digest_top.sv
// md5 message digest top level: controller plus datapath on valid/ready channels
// each accepted word is written into the block buffer; each filled block then runs
// load, 64 rounds at one per cycle, chaining add and spill-over byte write
// end of message: pad write and compression, then a length block and a second compression
// when the length spills, then four digest words, one per cycle while the sink is ready
// throughput: input is held off while a block is compressed by the single round unit
// reset: synchronous, loads the initial chaining values and clears bit count and fill
`timescale 1ns / 1ps

module md5_message_digest_top (
  input logic          clk,
  input logic          rst,
  md5_in_if.sink       msg,
  md5_out_if.source    dgst
);

  md5_pkg::cmd_t    cmd;
  md5_pkg::status_t st;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .out_valid (dgst.valid),
    .out_ready (dgst.ready),
    .st        (st),
    .cmd       (cmd)
  );

  md5_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .data_word   (msg.data_word),
    .byte_count  (msg.byte_count),
    .last        (msg.last),
    .digest_word (dgst.digest_word),
    .word_index  (dgst.word_index),
    .last_word   (dgst.last_word)
  );

endmodule

### test/md5_message_digest_top_test.sv
// self-checking testbench for the md5 message digest top level
`timescale 1ns / 1ps

module md5_message_digest_top_test;

  localparam int HOLD_CYCLES    = 700;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 200;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_LEFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_rec_t;

  logic clk;
  logic rst;

  md5_in_if  msg_if ();
  md5_out_if dgst_if ();

  md5_message_digest_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .msg  (msg_if),
    .dgst (dgst_if)
  );

  // running hash state of the predictor
  logic [31:0] chain_q [4];
  logic [63:0] bit_total;
  logic [31:0] blk_words [16];
  logic [5:0]  fill_pos;

  digest_rec_t expected_digest [$];

  int errors         = 0;
  int words_sent     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit sender_gaps_on = 1'b1;
  bit hold_req       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void md5_restart();
    for (int i = 0; i < 4; i++) chain_q[i] = CHAIN_INIT[i];
    bit_total = '0;
    fill_pos  = '0;
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, sum, rot, hold;
    int g, s;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s    = ROT_LEFT[(r / 16) * 4 + r % 4];
      sum  = a + f + SINE_ADD[r] + blk_words[g];
      rot  = (sum << s) | (sum >> (32 - s));
      hold = d;
      d    = c;
      c    = b;
      b    = b + rot;
      a    = hold;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endfunction

  function automatic void put_message_byte(input logic [5:0] pos, input logic [7:0] v);
    int sh;
    sh = 8 * int'(pos[1:0]);
    blk_words[pos[5:2]][sh +: 8] = v;
  endfunction

  // absorb one accepted word, queue the digest when it closes a message
  function automatic void md5_absorb_word(input logic [31:0] d, input logic [2:0] n,
                                          input logic l);
    int taken;
    logic [5:0] tail;
    digest_rec_t rec;
    taken = (n > 3'd4) ? 4 : int'(n);
    for (int i = 0; i < taken; i++) begin
      put_message_byte(fill_pos, d[8 * i +: 8]);
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) md5_compress();
    end
    bit_total = bit_total + 64'(taken * 8);
    if (l) begin
      tail = fill_pos;
      put_message_byte(tail, PAD_MARK);
      for (int i = int'(tail) + 1; i < 64; i++) put_message_byte(6'(i), 8'h00);
      // no room for the length, it goes in a block of its own
      if (tail >= 6'd56) begin
        md5_compress();
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
      end
      blk_words[14] = bit_total[31:0];
      blk_words[15] = bit_total[63:32];
      md5_compress();
      for (int i = 0; i < 4; i++) begin
        rec.digest_word = chain_q[i];
        rec.word_index  = 2'(i);
        rec.last_word   = (i == 3);
        expected_digest.push_back(rec);
      end
      md5_restart();
    end
  endfunction

  task automatic send_word(input logic [31:0] d, input logic [2:0] n, input logic l);
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        msg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    msg_if.valid      <= 1'b1;
    msg_if.data_word  <= d;
    msg_if.byte_count <= n;
    msg_if.last       <= l;
    do @(posedge clk); while (!msg_if.ready);
    md5_absorb_word(d, n, l);
    words_sent++;
  endtask

  task automatic send_random_message(input int n_body);
    logic [2:0] n;
    for (int i = 0; i < n_body; i++) begin
      // mostly full words, now and then a short, empty or oversized one
      n = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, n, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic test_known_messages();
    send_word(32'h0000_0000, 3'd0, 1'b1);   // empty message
    send_word(32'h0063_6261, 3'd3, 1'b1);   // "abc"
    send_word(32'hffff_ffff, 3'd7, 1'b1);   // count saturates at four
    send_word(32'h0000_0000, 3'd4, 1'b1);
    // short words mid-message keep the stream byte-packed
    send_word(32'h0000_00a5, 3'd1, 1'b0);
    send_word(32'h1234_5678, 3'd5, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b0);
    send_word(32'h0000_0000, 3'd6, 1'b1);
    send_word(32'hdead_beef, 3'd0, 1'b0);
    send_word(32'hcafe_f00d, 3'd3, 1'b1);
    // 56 bytes: length spills into a second block
    for (int i = 0; i < 14; i++)
      send_word((i % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd0, 1'b1);
  endtask

  task automatic test_random_messages();
    while (words_sent < 400) begin
      if ($urandom_range(0, 7) == 0)
        send_random_message($urandom_range(16, 40));
      else
        send_random_message($urandom_range(0, 17));
    end
  endtask

  // sink holds off while the source keeps offering short messages
  task automatic test_output_stall();
    sender_gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_random_message($urandom_range(0, 2));
    sender_gaps_on = 1'b1;
  endtask

  task automatic finish_run();
    msg_if.valid <= 1'b0;
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  endtask

  initial begin : main
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    md5_restart();
    rst               <= 1'b1;
    msg_if.valid      <= 1'b0;
    msg_if.data_word  <= '0;
    msg_if.byte_count <= '0;
    msg_if.last       <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_messages();
    test_random_messages();
    test_output_stall();
    finish_run();
  end

  initial begin : sink_side
    int hold_left;
    int mode_left;
    int phase;
    sink_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    phase = 0;
    mode = SINK_OPEN;
    dgst_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        dgst_if.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   dgst_if.ready <= 1'b1;
          SINK_RANDOM: dgst_if.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: dgst_if.ready <= ($urandom_range(0, 7) == 0);
          default:     dgst_if.ready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_digest
    digest_rec_t want;
    if (!rst && dgst_if.valid && dgst_if.ready) begin
      if (expected_digest.size() == 0) begin
        $error("digest word with none pending: %h", dgst_if.digest_word);
        errors++;
      end else begin
        want = expected_digest.pop_front();
        if (dgst_if.digest_word !== want.digest_word) begin
          $error("digest_word expected %h actual %h", want.digest_word, dgst_if.digest_word);
          errors++;
        end
        if (dgst_if.word_index !== want.word_index) begin
          $error("word_index expected %0d actual %0d", want.word_index, dgst_if.word_index);
          errors++;
        end
        if (dgst_if.last_word !== want.last_word) begin
          $error("last_word expected %b actual %b", want.last_word, dgst_if.last_word);
          errors++;
        end
      end
    end
  end

  // no word moving on either side for too long means the block hung
  always @(posedge clk) begin : watchdog
    if (rst || (msg_if.valid && msg_if.ready) || (dgst_if.valid && dgst_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
